[rtl/cplit_pkg.sv]
// ----------------------------------------------------------------------------
// cplit_pkg
// Types and constants shared by the contact pair lookup/insert table.
// ----------------------------------------------------------------------------
package cplit_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] CNT_LIMIT = 11'h401;
	localparam logic [CNT_W-1:0] CNT_STEP  = 11'h100;

	typedef struct packed {
		logic [KEY_W-1:0] key_first;
		logic [KEY_W-1:0] key_second;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] contact_value;
		logic             table_full;
	} rsp_t;

	// search token walking down the cell chain
	typedef struct packed {
		logic             act;
		logic [KEY_W-1:0] key_first;
		logic [KEY_W-1:0] key_second;
		logic             hit;
		logic [CNT_W-1:0] value;
	} probe_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} state_t;

endpackage

[rtl/cplit_cell.sv]
// ----------------------------------------------------------------------------
// cplit_cell
// One table entry: stored key pair and contact counter, compare and bump.
// ----------------------------------------------------------------------------
module cplit_cell import cplit_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             occ,
	input  logic             wr_en,
	input  logic [KEY_W-1:0] wr_first,
	input  logic [KEY_W-1:0] wr_second,
	input  probe_t           probe_i,
	output probe_t           probe_o
);

	logic [KEY_W-1:0] first_q;
	logic [KEY_W-1:0] second_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic             match;
	logic             sat;
	probe_t           probe_d;
	probe_t           probe_q;

	assign match    = probe_i.act & occ & (probe_i.key_first == first_q)
	                  & (probe_i.key_second == second_q);
	assign sat      = (cnt_q >= CNT_LIMIT);
	assign cnt_next = sat ? cnt_q : cnt_q + CNT_STEP;

	always_comb begin
		probe_d = probe_i;
		if (match) begin
			probe_d.hit   = 1'b1;
			probe_d.value = cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_q  <= wr_first;
			second_q <= wr_second;
			cnt_q    <= '0;
		end else if (match && !sat) begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign probe_o = probe_q;

endmodule

[rtl/contact_pair_lookup_insert_table_unit.sv]
// ----------------------------------------------------------------------------
// contact_pair_lookup_insert_table_unit
// Table of key pairs with saturating contact counters, built as a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one key pair per beat.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one beat per request.
//   A request with key_first zero empties the table and sends no token;
//   its response goes from the ST_RESULT state into the output register.
//   Any other request sends a search token down the chain of TABLE_DEPTH
//   cells, one cell per cycle; a hit bumps that cell's counter in passing.
//   At the chain end a miss is appended to the next free cell, or flagged
//   as table_full when all cells are taken.
//   The response follows the token's walk through the chain, the result
//   register res_q and the output register. One request is in flight at a
//   time, so a new request waits until the last one leaves ST_RESULT.
//   req_stall is high while a request is in flight. The finished response
//   sits in the output register, and the next request can be taken while
//   it waits on rsp_stall.
//   Reset empties the table and drops any request in flight.
// ----------------------------------------------------------------------------
module contact_pair_lookup_insert_table_unit import cplit_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t            state_q;
	state_t            state_d;
	logic [CW-1:0]     count_q;
	logic              accept;
	logic              is_clear;
	logic              full;
	logic              wr_go;
	logic              load;
	probe_t            probe_s [TABLE_DEPTH+1];
	logic [TABLE_DEPTH:0] act_vec;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	assign accept   = req_valid & ~req_stall;
	assign is_clear = (req.key_first == '0);
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign wr_go    = probe_s[TABLE_DEPTH].act & ~probe_s[TABLE_DEPTH].hit & ~full;
	assign load     = (state_q == ST_RESULT) & (~rsp_valid_q | ~rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s[0] <= '0;
		end else begin
			probe_s[0].act        <= accept & ~is_clear;
			probe_s[0].key_first  <= req.key_first;
			probe_s[0].key_second <= req.key_second;
			probe_s[0].hit        <= 1'b0;
			probe_s[0].value      <= '0;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cplit_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.occ       (count_q > CW'(i)),
			.wr_en     (wr_go && (count_q == CW'(i))),
			.wr_first  (probe_s[TABLE_DEPTH].key_first),
			.wr_second (probe_s[TABLE_DEPTH].key_second),
			.probe_i   (probe_s[i]),
			.probe_o   (probe_s[i+1])
		);
	end

	for (genvar j = 0; j <= TABLE_DEPTH; j++) begin : g_act
		assign act_vec[j] = probe_s[j].act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && is_clear) begin
			count_q <= '0;
		end else if (wr_go) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_clear) begin
			res_q <= '0;
		end else if (probe_s[TABLE_DEPTH].act) begin
			res_q.hit           <= probe_s[TABLE_DEPTH].hit;
			res_q.contact_value <= probe_s[TABLE_DEPTH].value;
			res_q.table_full    <= ~probe_s[TABLE_DEPTH].hit & full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = is_clear ? ST_RESULT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (probe_s[TABLE_DEPTH].act) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_tok_one: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(act_vec) <= 1)
		else $error("more than one search token in the chain");

	a_tok_state: assert property (@(posedge clk) disable iff (!arst_n)
		probe_s[TABLE_DEPTH].act |-> state_q == ST_SEARCH)
		else $error("token left the chain outside a search");

	a_count_rng: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_hit_val: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.table_full && rsp.contact_value >= CNT_STEP)
		else $error("hit response with bad value or full flag");

	a_miss_val: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.contact_value == '0)
		else $error("miss response with nonzero value");

endmodule

[test/contact_pair_lookup_insert_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_pair_lookup_insert_table_unit_tb
// Self-checking bench for the contact pair table. Key pairs are driven on the
// request channel with random gaps; a scoreboard keeps its own copy of the
// table and predicts hit, counter value and full flag for every beat, then
// checks each response beat in order. Covers clears, counter saturation, a
// full table and near-miss keys, with random stalls on the response side.
// ----------------------------------------------------------------------------
module contact_pair_lookup_insert_table_unit_tb;
	import cplit_pkg::*;

	localparam int DEPTH = 16;

	class contact_table_scoreboard;
		logic [KEY_W-1:0] pair_first[DEPTH];
		logic [KEY_W-1:0] pair_second[DEPTH];
		logic [CNT_W-1:0] pair_count[DEPTH];
		int used;
		rsp_t rsp_due[$];
		int errors;
		int beats;
		int hits;
		int saturated;
		int overflows;
		int clears;

		function void note_request(req_t r);
			rsp_t e;
			int k;
			bit found;
			e = '0;
			found = 1'b0;
			beats++;
			if (r.key_first == '0) begin
				used = 0;
				clears++;
			end else begin
				for (k = used - 1; k >= 0; k--) begin
					if (pair_first[k] == r.key_first && pair_second[k] == r.key_second) begin
						found = 1'b1;
						if (pair_count[k] < CNT_LIMIT)
							pair_count[k] = pair_count[k] + CNT_STEP;
						else
							saturated++;
						e.hit = 1'b1;
						e.contact_value = pair_count[k];
						hits++;
						break;
					end
				end
				if (!found) begin
					if (used == DEPTH) begin
						e.table_full = 1'b1;
						overflows++;
					end else begin
						pair_first[used] = r.key_first;
						pair_second[used] = r.key_second;
						pair_count[used] = '0;
						used++;
					end
				end
			end
			rsp_due.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (rsp_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat hit=%0b value=%0d full=%0b",
					$time, a.hit, a.contact_value, a.table_full);
				return;
			end
			e = rsp_due.pop_front();
			if (a.hit !== e.hit) begin
				errors++;
				$display("%0t: hit expected %0b actual %0b", $time, e.hit, a.hit);
			end
			if (a.contact_value !== e.contact_value) begin
				errors++;
				$display("%0t: contact_value expected %0d actual %0d",
					$time, e.contact_value, a.contact_value);
			end
			if (a.table_full !== e.table_full) begin
				errors++;
				$display("%0t: table_full expected %0b actual %0b",
					$time, e.table_full, a.table_full);
			end
		endfunction

		function int pending();
			return rsp_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	bit idle_on = 1'b0;
	bit stall_on = 1'b0;
	int stall_hold = 0;

	contact_table_scoreboard table_sb = new();

	contact_pair_lookup_insert_table_unit #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			table_sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			table_sb.check_response(rsp);
	end

	// response back-pressure: mostly short stalls, some long
	always @(negedge clk) begin
		if (!stall_on) begin
			rsp_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold = stall_hold - 1;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(99) < 30) begin
			stall_hold = ($urandom_range(9) < 8) ? $urandom_range(2, 0) : $urandom_range(30, 8);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_pair(input logic [KEY_W-1:0] kf, input logic [KEY_W-1:0] ks);
		int gap;
		int roll;
		roll = $urandom_range(99);
		if (!idle_on || roll < 55)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(3, 1);
		else
			gap = $urandom_range(25, 5);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= '{key_first: kf, key_second: ks};
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	initial begin
		#20_000_000;
		$display("contact_pair_lookup_insert_table_unit_tb NOT OK");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] base_first;
		logic [KEY_W-1:0] base_second;
		req_t pool[24];
		int pool_n;
		int run_len;
		int left;
		int pick;
		int i;
		int roll;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: clear, count up to saturation, key extremes, fill to full
		base_first = $urandom | 32'h1;
		base_second = $urandom;
		send_pair('0, $urandom);
		repeat (7) send_pair(base_first, base_second);
		send_pair('1, '0);
		send_pair(32'h1, '1);
		send_pair(base_first, base_second ^ 32'h1);
		for (i = 0; i < 12; i++)
			send_pair(32'h8000_0000 + i, base_second);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000);
		send_pair(base_first, base_second);
		send_pair('0, '1);

		// random episodes: clear, then traffic over a small pool of pairs
		left = 850;
		while (left > 0) begin
			idle_on = ($urandom_range(3) != 0);
			stall_on = ($urandom_range(3) != 0);
			send_pair('0, $urandom);
			left--;
			roll = $urandom_range(9);
			if (roll < 6)
				pool_n = $urandom_range(8, 1);
			else if (roll < 8)
				pool_n = $urandom_range(16, 9);
			else
				pool_n = $urandom_range(24, 17);
			for (i = 0; i < pool_n; i++) begin
				pool[i].key_first = $urandom;
				pool[i].key_second = $urandom;
				if (i > 0 && $urandom_range(3) == 0)
					pool[i].key_first = pool[$urandom_range(i - 1)].key_first;
				else if (i > 0 && $urandom_range(3) == 0)
					pool[i].key_second = pool[$urandom_range(i - 1)].key_second;
				if (pool[i].key_first == '0)
					pool[i].key_first = 32'h1;
			end
			run_len = $urandom_range(pool_n * 4 + 8, 4);
			for (i = 0; i < run_len && left > 0; i++) begin
				roll = $urandom_range(99);
				if (roll < 3) begin
					send_pair('0, $urandom);
				end else if (roll < 10) begin
					send_pair($urandom, $urandom);
				end else begin
					pick = $urandom_range(pool_n - 1);
					send_pair(pool[pick].key_first, pool[pick].key_second);
				end
				left--;
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (table_sb.pending() > 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Ran %0d beats: %0d clears, %0d hits (%0d on a saturated counter), %0d full-table misses.",
			table_sb.beats, table_sb.clears, table_sb.hits, table_sb.saturated,
			table_sb.overflows);
		$display("Mismatches found: %0d", table_sb.errors);
		if (table_sb.errors == 0 && table_sb.pending() == 0)
			$display("contact_pair_lookup_insert_table_unit_tb OK");
		else
			$display("contact_pair_lookup_insert_table_unit_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
rtl/cplit_pkg.sv
rtl/cplit_cell.sv
rtl/contact_pair_lookup_insert_table_unit.sv
test/contact_pair_lookup_insert_table_unit_tb.sv
